@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ sv/mpbr_pkg.sv @@
`default_nettype none

package mpbr_pkg;

    localparam int NUM_PATTERNS_DEF = 4;
    localparam int MAX_BYTES_DEF    = 8;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 2;
    localparam int POS_W  = 3;
    localparam int SIZE_W = 4;
    localparam int BYTE_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_DATA = 2'd0,
        CMD_LOAD = 2'd1,
        CMD_SIZE = 2'd2,
        CMD_NONE = 2'd3
    } command_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } beat_t;

    typedef struct packed {
        logic              load;
        logic              set_size;
        logic [POS_W-1:0]  position;
        logic [BYTE_W-1:0] original;
        logic [BYTE_W-1:0] replacement;
        logic [SIZE_W-1:0] size;
    } cfg_t;

endpackage

`default_nettype wire

@@ sv/mpbr_if.sv @@
`default_nettype none

interface mpbr_item_if;
    import mpbr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  pattern_index;
    logic [POS_W-1:0]  byte_position;
    logic [BYTE_W-1:0] original_byte;
    logic [BYTE_W-1:0] replacement_byte;
    logic [SIZE_W-1:0] pattern_size;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (
        output valid, command, pattern_index, byte_position, original_byte,
               replacement_byte, pattern_size, data_byte, last,
        input  ready
    );

    modport sink (
        input  valid, command, pattern_index, byte_position, original_byte,
               replacement_byte, pattern_size, data_byte, last,
        output ready
    );
endinterface

interface mpbr_result_if;
    import mpbr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;

    modport source (
        output valid, out_byte, out_last,
        input  ready
    );

    modport sink (
        input  valid, out_byte, out_last,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/multi_pattern_byte_replacer.sv @@
// multi_pattern_byte_replacer
//
// Rewrites a byte stream with up to NUM_PATTERNS search/replace patterns of up
// to MAX_PATTERN_BYTES bytes, applied in table order, one cell per pattern.
// item (valid/ready): one request per cycle while ready. command selects a data
// byte, a pattern byte pair load (pattern_index, byte_position, original_byte,
// replacement_byte) or a size set (pattern_index, pattern_size, 0 disables).
// result (valid/ready): the patched bytes in original order, out_last on the
// final byte of a buffer.
// Throughput: one data byte per cycle in steady state while result.ready is
// high. A byte leaves a cell once its window holds the next (size - 1) bytes
// of its buffer; each cell holds it in a window and then an output register.
// A byte with last set flushes every cell: held bytes come out one per cycle
// unless stalled; a cell takes no new data until its own held bytes have left.
// Load and size requests wait until no byte is moving between cells.
// Reset clears all patterns (all disabled) and empties every cell.
// A stalled result holds in the last cell's output register; bytes keep
// entering until the cell windows fill, then item.ready drops.

`default_nettype none

module multi_pattern_byte_replacer #(
    parameter int NUM_PATTERNS      = mpbr_pkg::NUM_PATTERNS_DEF,
    parameter int MAX_PATTERN_BYTES = mpbr_pkg::MAX_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    mpbr_item_if.sink     item,
    mpbr_result_if.source result
);
    import mpbr_pkg::*;

    logic  link_valid [NUM_PATTERNS+1];
    logic  link_ready [NUM_PATTERNS+1];
    beat_t link_beat  [NUM_PATTERNS+1];
    logic  cell_busy  [NUM_PATTERNS];
    cfg_t  cell_cfg   [NUM_PATTERNS];
    logic  idle;
    logic  accept;

    always_comb
    begin
        idle = 1'b1;
        for (int k = 0; k < NUM_PATTERNS; k++)
        begin
            if (cell_busy[k])
            begin
                idle = 1'b0;
            end
        end
    end

    always_comb
    begin
        unique case (item.command)
            CMD_DATA:           item.ready = link_ready[0];
            CMD_LOAD, CMD_SIZE: item.ready = idle;
            CMD_NONE:           item.ready = 1'b1;
        endcase
    end

    assign accept = item.valid && item.ready;

    assign link_valid[0]     = item.valid && (item.command == CMD_DATA);
    assign link_beat[0].data = item.data_byte;
    assign link_beat[0].last = item.last;

    for (genvar k = 0; k < NUM_PATTERNS; k++)
    begin : g_cell
        always_comb
        begin
            cell_cfg[k].load        = accept && (item.command == CMD_LOAD)
                                      && (item.pattern_index == IDX_W'(k));
            cell_cfg[k].set_size    = accept && (item.command == CMD_SIZE)
                                      && (item.pattern_index == IDX_W'(k));
            cell_cfg[k].position    = item.byte_position;
            cell_cfg[k].original    = item.original_byte;
            cell_cfg[k].replacement = item.replacement_byte;
            cell_cfg[k].size        = item.pattern_size;
        end

        mpbr_cell #(
            .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (cell_cfg[k]),
            .in_valid  (link_valid[k]),
            .in_beat   (link_beat[k]),
            .in_ready  (link_ready[k]),
            .out_valid (link_valid[k+1]),
            .out_beat  (link_beat[k+1]),
            .out_ready (link_ready[k+1]),
            .busy      (cell_busy[k])
        );
    end

    assign result.valid              = link_valid[NUM_PATTERNS];
    assign result.out_byte           = link_beat[NUM_PATTERNS].data;
    assign result.out_last           = link_beat[NUM_PATTERNS].last;
    assign link_ready[NUM_PATTERNS]  = result.ready;

endmodule

`default_nettype wire

@@ sv/mpbr_cell.sv @@
`default_nettype none

module mpbr_cell #(
    parameter int MAX_PATTERN_BYTES = mpbr_pkg::MAX_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mpbr_pkg::cfg_t cfg,
    input  logic           in_valid,
    input  mpbr_pkg::beat_t in_beat,
    output logic           in_ready,
    output logic           out_valid,
    output mpbr_pkg::beat_t out_beat,
    input  logic           out_ready,
    output logic           busy
);
    import mpbr_pkg::*;

    localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);

    logic [BYTE_W-1:0] win_reg  [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0] win_next [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0] shifted  [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0] orig_reg [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0] repl_reg [MAX_PATTERN_BYTES];
    logic [FILL_W-1:0] size_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] wpos;
    logic              armed_reg;
    logic              flush_reg;
    logic              out_valid_reg;
    beat_t             out_beat_reg;

    logic              need;
    logic              compare;
    logic              drain;
    logic              emit;
    logic              append;
    logic              match;
    logic              hit;
    logic [BYTE_W-1:0] head;
    logic              tag;

    always_comb
    begin
        need     = (fill_reg >= size_reg) && (fill_reg != '0);
        compare  = armed_reg && need;
        drain    = compare || (flush_reg && (fill_reg != '0));
        emit     = drain && (!out_valid_reg || out_ready);
        in_ready = !flush_reg && ((fill_reg < FILL_W'(MAX_PATTERN_BYTES)) || emit);
        append   = in_valid && in_ready;

        match = 1'b1;
        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
        begin
            if ((j < int'(size_reg)) && (win_reg[j] != orig_reg[j]))
            begin
                match = 1'b0;
            end
        end
        hit  = compare && match && (size_reg != '0);
        head = hit ? repl_reg[0] : win_reg[0];
        tag  = flush_reg && (fill_reg == FILL_W'(1));

        // window after the oldest byte leaves, with replacement applied on a hit
        for (int j = 0; j < MAX_PATTERN_BYTES - 1; j++)
        begin
            shifted[j] = (hit && ((j + 1) < int'(size_reg))) ? repl_reg[j+1] : win_reg[j+1];
        end
        shifted[MAX_PATTERN_BYTES-1] = win_reg[MAX_PATTERN_BYTES-1];

        wpos = emit ? (fill_reg - FILL_W'(1)) : fill_reg;
        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
        begin
            win_next[j] = emit ? shifted[j] : win_reg[j];
            if (append && (FILL_W'(j) == wpos))
            begin
                win_next[j] = in_beat.data;
            end
        end

        fill_next = fill_reg + FILL_W'(append) - FILL_W'(emit);
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (emit)
        begin
            out_beat_reg.data <= head;
            out_beat_reg.last <= tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_PATTERN_BYTES; j++)
            begin
                orig_reg[j] <= '0;
                repl_reg[j] <= '0;
            end
            size_reg      <= '0;
            fill_reg      <= '0;
            armed_reg     <= 1'b0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int j = 0; j < MAX_PATTERN_BYTES; j++)
            begin
                if (cfg.load && (int'(cfg.position) == j))
                begin
                    orig_reg[j] <= cfg.original;
                    repl_reg[j] <= cfg.replacement;
                end
            end
            if (cfg.set_size)
            begin
                if (cfg.size > SIZE_W'(MAX_PATTERN_BYTES))
                begin
                    size_reg <= FILL_W'(MAX_PATTERN_BYTES);
                end
                else
                begin
                    size_reg <= FILL_W'(cfg.size);
                end
            end

            fill_reg  <= fill_next;
            armed_reg <= append || (armed_reg && need);

            if (append && in_beat.last)
            begin
                flush_reg <= 1'b1;
            end
            else if (emit && tag)
            begin
                flush_reg <= 1'b0;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;
    assign busy      = armed_reg || flush_reg || out_valid_reg;

endmodule

`default_nettype wire

@@ sv/mpbr_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module mpbr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_ready,
    input logic [mpbr_pkg::CMD_W-1:0]  item_command,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [mpbr_pkg::BYTE_W-1:0] result_out_byte,
    input logic                        result_out_last
);
    import mpbr_pkg::*;

    `ASSERT_NEXT(a_result_holds_valid, result_valid && !result_ready, result_valid)
    `ASSERT_NEXT(a_result_holds_data, result_valid && !result_ready, $stable(result_out_byte) && $stable(result_out_last))
    `ASSERT_IMPLIES(a_unknown_cmd_taken, item_valid && (item_command == CMD_NONE), item_ready)
    // a table update never slips in right behind a data byte still in flight
    `ASSERT_IMPLIES(a_cfg_waits_for_data, $past(rst_n) && $past(item_valid && item_ready && (item_command == CMD_DATA)) && item_valid && ((item_command == CMD_LOAD) || (item_command == CMD_SIZE)), !item_ready)

endmodule

bind multi_pattern_byte_replacer mpbr_checker u_mpbr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .item_command    (item.command),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_out_byte (result.out_byte),
    .result_out_last (result.out_last)
);

`default_nettype wire
